### rtl/tem_pkg.sv
// Package with the constants, codes and helper functions of the triple excitation element core.
`default_nettype none
package tem_pkg;

  // Number of orbitals per index; index fields are fixed at two bits.
  localparam int ORBITALS = 4;
  localparam int IDX_W    = 2;

  localparam int ONE_DEPTH   = ORBITALS ** 2;
  localparam int TWO_DEPTH   = ORBITALS ** 4;
  localparam int THREE_DEPTH = ORBITALS ** 6;
  localparam int ONE_AW   = (ONE_DEPTH > 1) ? $clog2(ONE_DEPTH) : 1;
  localparam int TWO_AW   = (TWO_DEPTH > 1) ? $clog2(TWO_DEPTH) : 1;
  localparam int THREE_AW = (THREE_DEPTH > 1) ? $clog2(THREE_DEPTH) : 1;

  // Function codes of an input word.
  localparam logic [1:0] FUNC_ONE   = 2'd0;
  localparam logic [1:0] FUNC_TWO   = 2'd1;
  localparam logic [1:0] FUNC_THREE = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  // Canonical quiet NaN and the magnitude threshold 1e-14.
  localparam logic [63:0] QNAN   = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] THRESH = 64'h3D06_849B_86A1_2B9B;

  typedef logic [IDX_W-1:0] idx_t;

  function automatic logic in_range(input idx_t x);
    return (int'(x) < ORBITALS);
  endfunction

  function automatic logic [ONE_AW-1:0] flat2(input idx_t a, input idx_t b);
    int acc;
    acc = int'(a) * ORBITALS + int'(b);
    return ONE_AW'(acc);
  endfunction

  function automatic logic [TWO_AW-1:0] flat4(input idx_t a, input idx_t b,
                                              input idx_t c, input idx_t d);
    int acc;
    acc = ((int'(a) * ORBITALS + int'(b)) * ORBITALS + int'(c)) * ORBITALS + int'(d);
    return TWO_AW'(acc);
  endfunction

  function automatic logic [THREE_AW-1:0] flat6(input idx_t a, input idx_t b,
                                                input idx_t c, input idx_t d,
                                                input idx_t e, input idx_t f);
    int acc;
    acc = int'(a);
    acc = acc * ORBITALS + int'(b);
    acc = acc * ORBITALS + int'(c);
    acc = acc * ORBITALS + int'(d);
    acc = acc * ORBITALS + int'(e);
    acc = acc * ORBITALS + int'(f);
    return THREE_AW'(acc);
  endfunction

  // Exact product of a double by 2.0.
  function automatic logic [63:0] dbl_twice(input logic [63:0] x);
    logic [10:0] e;
    e = x[62:52];
    if (e == 11'h7FF) begin
      return x;
    end else if (e == 11'h000) begin
      return {x[63], x[61:0], 1'b0};
    end else if (e == 11'h7FE) begin
      return {x[63], 11'h7FF, 52'd0};
    end else begin
      return {x[63], e + 11'd1, x[51:0]};
    end
  endfunction

  // Product of a double by 0.0: NaN for infinities and NaNs, else a signed zero.
  function automatic logic [63:0] dbl_zero(input logic [63:0] x);
    if (x[62:52] == 11'h7FF) begin
      return QNAN;
    end else begin
      return {x[63], 63'd0};
    end
  endfunction

endpackage
`default_nettype wire

### rtl/tem_req_if.sv
// Request channel interface: operation words into the core.
`default_nettype none
interface tem_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  idx_a;
  logic [1:0]  idx_b;
  logic [1:0]  idx_c;
  logic [1:0]  idx_d;
  logic [1:0]  idx_e;
  logic [1:0]  idx_f;
  logic [63:0] entry_value;

  modport source (output valid, func, idx_a, idx_b, idx_c, idx_d, idx_e, idx_f,
                  entry_value, input ready);
  modport sink (input valid, func, idx_a, idx_b, idx_c, idx_d, idx_e, idx_f,
                entry_value, output ready);
endinterface
`default_nettype wire

### rtl/tem_rsp_if.sv
// Response channel interface: matrix element words out of the core.
`default_nettype none
interface tem_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] element_value;
  logic        above_threshold;

  modport source (output valid, element_value, above_threshold, input ready);
  modport sink (input valid, element_value, above_threshold, output ready);
endinterface
`default_nettype wire

### rtl/tem_ram.sv
// Generic single write port RAM with a registered, enabled read port.
`default_nettype none
module tem_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### rtl/tem_fadd.sv
// Four-stage pipelined double-precision adder with round to nearest even.
`default_nettype none
module tem_fadd (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  input  wire logic [191:0] side_in,
  input  wire logic         flag_in,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic      [63:0]  sum,
  output logic      [191:0] side_out,
  output logic              flag_out
);
  import tem_pkg::*;

  logic va, vb, vc, vd;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  // Stall chain: a stage loads when it is empty or its contents move on.
  assign rdy_d    = !vd || out_ready;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
    end
  end

  // Stage A: special values, operand ordering and exponent difference.
  logic [10:0]  ea_f, eb_f;
  logic         nan_a, nan_b, inf_a, inf_b;
  logic         swap;
  logic [63:0]  big, sml;
  logic [10:0]  e_big, e_sml;
  logic [63:0]  spec_val_a;

  always_comb begin
    ea_f  = a[62:52];
    eb_f  = b[62:52];
    nan_a = (ea_f == 11'h7FF) && (a[51:0] != 52'd0);
    nan_b = (eb_f == 11'h7FF) && (b[51:0] != 52'd0);
    inf_a = (ea_f == 11'h7FF) && (a[51:0] == 52'd0);
    inf_b = (eb_f == 11'h7FF) && (b[51:0] == 52'd0);
    if (nan_a || nan_b || (inf_a && inf_b && (a[63] != b[63]))) begin
      spec_val_a = QNAN;
    end else if (inf_a) begin
      spec_val_a = a;
    end else begin
      spec_val_a = b;
    end
    swap  = b[62:0] > a[62:0];
    big   = swap ? b : a;
    sml   = swap ? a : b;
    e_big = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    e_sml = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
  end

  logic         sgn_a, sub_a, spec_a, flag_a;
  logic [10:0]  eb_a, d_a;
  logic [52:0]  mb_a, ms_a;
  logic [63:0]  sv_a;
  logic [191:0] side_a;

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      sgn_a  <= big[63];
      sub_a  <= a[63] ^ b[63];
      spec_a <= nan_a || nan_b || inf_a || inf_b;
      sv_a   <= spec_val_a;
      eb_a   <= e_big;
      d_a    <= e_big - e_sml;
      mb_a   <= {big[62:52] != 11'd0, big[51:0]};
      ms_a   <= {sml[62:52] != 11'd0, sml[51:0]};
      side_a <= side_in;
      flag_a <= flag_in;
    end
  end

  // Stage B: alignment with sticky bit, then add or subtract.
  logic [5:0]   dc;
  logic [111:0] shl;
  logic [55:0]  ss, bx;
  logic [56:0]  raw;

  always_comb begin
    dc  = (d_a > 11'd63) ? 6'd63 : d_a[5:0];
    shl = {ms_a, 3'b000, 56'd0} >> dc;
    ss  = {shl[111:57], shl[56] | (shl[55:0] != 56'd0)};
    bx  = {mb_a, 3'b000};
    raw = sub_a ? ({1'b0, bx} - {1'b0, ss}) : ({1'b0, bx} + {1'b0, ss});
  end

  logic         sgn_b, spec_b, flag_b;
  logic [10:0]  eb_b;
  logic [56:0]  sum_b;
  logic [63:0]  sv_b;
  logic [191:0] side_b;

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      sgn_b  <= sgn_a;
      spec_b <= spec_a;
      sv_b   <= sv_a;
      eb_b   <= eb_a;
      sum_b  <= raw;
      side_b <= side_a;
      flag_b <= flag_a;
    end
  end

  // Stage C: leading zero count of the raw sum.
  logic [5:0] lz;

  always_comb begin
    lz = 6'd57;
    for (int i = 0; i < 57; i++) begin
      if (sum_b[i]) lz = 6'(56 - i);
    end
  end

  logic         sgn_c, spec_c, flag_c;
  logic [10:0]  eb_c;
  logic [56:0]  sum_c;
  logic [5:0]   lz_c;
  logic [63:0]  sv_c;
  logic [191:0] side_c;

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      sgn_c  <= sgn_b;
      spec_c <= spec_b;
      sv_c   <= sv_b;
      eb_c   <= eb_b;
      sum_c  <= sum_b;
      lz_c   <= lz;
      side_c <= side_b;
      flag_c <= flag_b;
    end
  end

  // Stage D: normalise (stopping at the subnormal range), round and pack.
  logic [5:0]  sh;
  logic [56:0] nrm;
  logic [11:0] er;
  logic        inc, ovf, sgn_r;
  logic [10:0] ef;
  logic [62:0] packed_mag;
  logic [63:0] res;

  always_comb begin
    sh         = ({5'd0, lz_c} > eb_c) ? eb_c[5:0] : lz_c;
    nrm        = sum_c << sh;
    er         = {1'b0, eb_c} + 12'd1 - {6'd0, sh};
    inc        = nrm[3] && ((nrm[2:0] != 3'd0) || nrm[4]);
    ef         = nrm[56] ? er[10:0] : 11'd0;
    ovf        = nrm[56] && (er >= 12'd2047);
    packed_mag = {ef, nrm[55:4]} + {62'd0, inc};
    sgn_r      = (sum_c == 57'd0) ? 1'b0 : sgn_c;
    if (spec_c) begin
      res = sv_c;
    end else if (ovf) begin
      res = {sgn_c, 11'h7FF, 52'd0};
    end else begin
      res = {sgn_r, packed_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      sum      <= res;
      side_out <= side_c;
      flag_out <= flag_c;
    end
  end

  assign out_valid = vd;
endmodule
`default_nettype wire

### rtl/triple_excitation_matrix_element_core.sv
// Top level of the triple excitation matrix element core.
// The core holds the one-, two- and three-body density tensors as doubles.
// Words arrive on the req channel (valid/ready). Function codes 0, 1 and 2
// write one entry of the one-, two- or three-body store and give no response;
// code 3 queries the element for indices i,j,k,l,m,n and gives one word on
// the rsp channel with the element and its above-threshold flag.
// A write lands at its accept edge, so a query accepted in the next cycle
// already sees it. A query's response passes the store read, term forming,
// four chained four-stage double adders and the output register. One word
// is taken every cycle unless a stalled receiver has filled the pipeline.
// Reset clears all pipeline valid bits; store contents are undefined until
// software writes them, and every entry must be written before it is read.
// When the receiver stalls, each pipeline stage holds once its successor is
// full, so bubbles are squeezed out and req.ready falls only when the whole
// pipeline is occupied; nothing is dropped or repeated.
`default_nettype none
module triple_excitation_matrix_element_core (
  input  wire logic clk,
  input  wire logic rst,
  tem_req_if.sink   req,
  tem_rsp_if.source rsp
);
  import tem_pkg::*;

  logic acc;
  logic rdy1, rdy2, out_rdy;
  logic v1, v2;
  logic add1_rdy, add4_v;

  // Write side: store writes happen at the accept edge.
  logic wr_ok_one, wr_ok_two, wr_ok_three;
  logic all_ok;

  assign acc = req.valid && req.ready;

  always_comb begin
    wr_ok_one   = in_range(req.idx_a) && in_range(req.idx_b);
    wr_ok_two   = wr_ok_one && in_range(req.idx_c) && in_range(req.idx_d);
    wr_ok_three = wr_ok_two && in_range(req.idx_e) && in_range(req.idx_f);
    all_ok      = wr_ok_three;
  end

  logic we_one, we_two, we_three;
  assign we_one   = acc && (req.func == FUNC_ONE) && wr_ok_one;
  assign we_two   = acc && (req.func == FUNC_TWO) && wr_ok_two;
  assign we_three = acc && (req.func == FUNC_THREE) && wr_ok_three;

  // Write and read addresses: i=a j=b k=c l=d m=e n=f.
  logic [ONE_AW-1:0]   wa_one, ra_one;
  logic [TWO_AW-1:0]   wa_two, ra_two0, ra_two1, ra_two2;
  logic [THREE_AW-1:0] wa_three, ra_three;

  always_comb begin
    wa_one   = flat2(req.idx_a, req.idx_b);
    wa_two   = flat4(req.idx_a, req.idx_b, req.idx_c, req.idx_d);
    wa_three = flat6(req.idx_a, req.idx_b, req.idx_c, req.idx_d, req.idx_e, req.idx_f);
    ra_one   = flat2(req.idx_a, req.idx_f);
    ra_two0  = flat4(req.idx_a, req.idx_e, req.idx_f, req.idx_d);
    ra_two1  = flat4(req.idx_a, req.idx_c, req.idx_f, req.idx_b);
    ra_two2  = flat4(req.idx_a, req.idx_c, req.idx_d, req.idx_f);
    ra_three = flat6(req.idx_a, req.idx_c, req.idx_e, req.idx_f, req.idx_d, req.idx_b);
  end

  logic [63:0] rd_one, rd_two0, rd_two1, rd_two2, rd_three;

  tem_ram #(.WIDTH(64), .DEPTH(ONE_DEPTH)) u_one (
    .clk(clk), .we(we_one), .waddr(wa_one), .wdata(req.entry_value),
    .re(rdy1), .raddr(ra_one), .rdata(rd_one)
  );

  // Three copies of the two-body store give three reads per query.
  tem_ram #(.WIDTH(64), .DEPTH(TWO_DEPTH)) u_two0 (
    .clk(clk), .we(we_two), .waddr(wa_two), .wdata(req.entry_value),
    .re(rdy1), .raddr(ra_two0), .rdata(rd_two0)
  );

  tem_ram #(.WIDTH(64), .DEPTH(TWO_DEPTH)) u_two1 (
    .clk(clk), .we(we_two), .waddr(wa_two), .wdata(req.entry_value),
    .re(rdy1), .raddr(ra_two1), .rdata(rd_two1)
  );

  tem_ram #(.WIDTH(64), .DEPTH(TWO_DEPTH)) u_two2 (
    .clk(clk), .we(we_two), .waddr(wa_two), .wdata(req.entry_value),
    .re(rdy1), .raddr(ra_two2), .rdata(rd_two2)
  );

  tem_ram #(.WIDTH(64), .DEPTH(THREE_DEPTH)) u_three (
    .clk(clk), .we(we_three), .waddr(wa_three), .wdata(req.entry_value),
    .re(rdy1), .raddr(ra_three), .rdata(rd_three)
  );

  // Stall chain for the read and term stages.
  assign rdy2      = !v2 || add1_rdy;
  assign rdy1      = !v1 || rdy2;
  assign req.ready = rdy1;

  // Stage 1: store read data plus the index deltas.
  logic djk1, dlm1, djm1, bad1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= acc && (req.func == FUNC_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      djk1 <= req.idx_b == req.idx_c;
      dlm1 <= req.idx_d == req.idx_e;
      djm1 <= req.idx_b == req.idx_e;
      bad1 <= !all_ok;
    end
  end

  // Stage 2: each term is its store value times 0.0, 1.0 or 2.0.
  logic [63:0] t1, t2, t3, t4, t5;
  logic        bad2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      t1   <= (djk1 && dlm1) ? rd_one : dbl_zero(rd_one);
      t2   <= djk1 ? dbl_twice(rd_two0) : dbl_zero(rd_two0);
      t3   <= dlm1 ? dbl_twice(rd_two1) : dbl_zero(rd_two1);
      t4   <= djm1 ? dbl_twice(rd_two2) : dbl_zero(rd_two2);
      t5   <= rd_three;
      bad2 <= bad1;
    end
  end

  // Adder chain: the remaining terms ride along in the side word.
  logic         a1_v, a2_v, a3_v, a2_rdy, a3_rdy, a4_rdy;
  logic [63:0]  s1, s2, s3, s4;
  logic [191:0] sd1, sd2, sd3;
  logic         f1, f2, f3, f4;

  tem_fadd u_add1 (
    .clk(clk), .rst(rst), .in_valid(v2), .in_ready(add1_rdy),
    .a(t1), .b(t2), .side_in({t3, t4, t5}), .flag_in(bad2),
    .out_valid(a1_v), .out_ready(a2_rdy), .sum(s1), .side_out(sd1), .flag_out(f1)
  );

  tem_fadd u_add2 (
    .clk(clk), .rst(rst), .in_valid(a1_v), .in_ready(a2_rdy),
    .a(s1), .b(sd1[191:128]), .side_in({sd1[127:0], 64'd0}), .flag_in(f1),
    .out_valid(a2_v), .out_ready(a3_rdy), .sum(s2), .side_out(sd2), .flag_out(f2)
  );

  tem_fadd u_add3 (
    .clk(clk), .rst(rst), .in_valid(a2_v), .in_ready(a3_rdy),
    .a(s2), .b(sd2[191:128]), .side_in({sd2[127:0], 64'd0}), .flag_in(f2),
    .out_valid(a3_v), .out_ready(a4_rdy), .sum(s3), .side_out(sd3), .flag_out(f3)
  );

  tem_fadd u_add4 (
    .clk(clk), .rst(rst), .in_valid(a3_v), .in_ready(a4_rdy),
    .a(s3), .b(sd3[191:128]), .side_in({sd3[127:0], 64'd0}), .flag_in(f3),
    .out_valid(add4_v), .out_ready(out_rdy), .sum(s4), .side_out(), .flag_out(f4)
  );

  // Output register with the threshold test; NaN never passes.
  logic above;
  assign out_rdy = !rsp.valid || rsp.ready;
  assign above   = !f4 && !((s4[62:52] == 11'h7FF) && (s4[51:0] != 52'd0))
                   && (s4[62:0] > THRESH[62:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_rdy) begin
      rsp.valid <= add4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      rsp.element_value   <= above ? s4 : 64'd0;
      rsp.above_threshold <= above;
    end
  end

`ifndef SYNTHESIS
  a_zero_when_low: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.above_threshold |-> rsp.element_value == 64'd0)
    else $error("element below threshold is not zero");

  a_flag_magnitude: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.above_threshold |-> rsp.element_value[62:0] > THRESH[62:0])
    else $error("flagged element is not above threshold");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    acc && (req.func != FUNC_QUERY) |=> !v1)
    else $error("store write entered the query pipeline");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid && !v1 && !v2)
    else $error("pipeline not empty after reset");
`endif
endmodule
`default_nettype wire

### dv/triple_excitation_matrix_element_core_test.sv
// Self-checking testbench for the triple excitation matrix element core.
`timescale 1ns / 1ps
module triple_excitation_matrix_element_core_test;
  import tem_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    idx_t        a, b, c, d, e, f;
    logic [63:0] value;
  } req_word_t;

  typedef struct packed {
    logic [63:0] element;
    logic        flag;
  } element_t;

  // Keeps a copy of the three tensors and the queue of elements still owed.
  class element_ledger;
    logic [63:0] one_st [ONE_DEPTH];
    logic [63:0] two_st [TWO_DEPTH];
    logic [63:0] three_st [THREE_DEPTH];
    element_t    owed_elements[$];
    int          errors;

    function automatic element_t element_of(req_word_t w);
      element_t r;
      real djk, dlm, djm, acc;
      djk = (w.b == w.c) ? 1.0 : 0.0;
      dlm = (w.d == w.e) ? 1.0 : 0.0;
      djm = (w.b == w.e) ? 1.0 : 0.0;
      acc = 0.0;
      // Terms in the fixed order i,j,k,l,m,n = a..f; absent terms still add zero times.
      acc = acc + (djk * dlm) * $bitstoreal(one_st[{w.a, w.f}]);
      acc = acc + (djk * 2.0) * $bitstoreal(two_st[{w.a, w.e, w.f, w.d}]);
      acc = acc + (dlm * 2.0) * $bitstoreal(two_st[{w.a, w.c, w.f, w.b}]);
      acc = acc + (djm * 2.0) * $bitstoreal(two_st[{w.a, w.c, w.d, w.f}]);
      acc = acc + $bitstoreal(three_st[{w.a, w.c, w.e, w.f, w.d, w.b}]);
      r = '0;
      if (acc > 1e-14 || acc < -1e-14) begin
        r.element = $realtobits(acc);
        r.flag    = 1'b1;
      end
      return r;
    endfunction

    // Applies an accepted word: writes update a store, queries owe one element.
    function void note_word(req_word_t w);
      case (w.func)
        FUNC_ONE:   one_st[{w.a, w.b}] = w.value;
        FUNC_TWO:   two_st[{w.a, w.b, w.c, w.d}] = w.value;
        FUNC_THREE: three_st[{w.a, w.b, w.c, w.d, w.e, w.f}] = w.value;
        default:    owed_elements.push_back(element_of(w));
      endcase
    endfunction

    function void check_result(logic [63:0] element, logic flag);
      element_t x;
      if (owed_elements.size() == 0) begin
        $error("unexpected element word %h flag %b", element, flag);
        errors++;
        return;
      end
      x = owed_elements.pop_front();
      if (element !== x.element) begin
        $error("element_value: expected %h, got %h", x.element, element);
        errors++;
      end
      if (flag !== x.flag) begin
        $error("above_threshold: expected %b, got %b", x.flag, flag);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle = 0;
  int   snk_stall = 0;
  int   cycles = 0;
  int   n_sent = 0;

  element_ledger ledger = new();

  // Entries the stimulus has loaded; queries never touch anything else.
  bit one_done [ONE_DEPTH];
  bit two_done [TWO_DEPTH];
  bit three_done [THREE_DEPTH];

  tem_req_if req_ch ();
  tem_rsp_if rsp_ch ();

  triple_excitation_matrix_element_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_ONE;
    {req_ch.idx_a, req_ch.idx_b, req_ch.idx_c} = '0;
    {req_ch.idx_d, req_ch.idx_e, req_ch.idx_f} = '0;
    req_ch.entry_value = '0;
    rsp_ch.ready = 1'b0;
  end

  // Receiver: ready changes on the falling edge with the current stall rate.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(1, 100) > snk_stall);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      ledger.check_result(rsp_ch.element_value, rsp_ch.above_threshold);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // A tensor entry: mostly moderate values, with zeros, specials and tiny ones.
  function automatic logic [63:0] entry_bits();
    int sel;
    real r;
    sel = $urandom_range(0, 19);
    case (sel)
      0: return {1'($urandom), 63'd0};
      1: return {1'($urandom), 11'h7FF, 52'd0};
      2: return {1'($urandom), 11'h7FF, 20'($urandom), 32'($urandom) | 32'd1};
      3, 4: begin
        r = $urandom_range(1, 40) * 1e-15;
        return {1'($urandom), 63'($realtobits(r))};
      end
      5: return {1'($urandom), 11'h000, 20'($urandom), 32'($urandom)};
      6: return {1'($urandom), 11'h7FE, 20'($urandom), 32'($urandom)};
      7, 8: return {$urandom, $urandom};
      default: begin
        r = (real'($urandom_range(0, 4000)) - 2000.0) / 64.0;
        return $realtobits(r);
      end
    endcase
  endfunction

  // Hands one word to the core and records it at its accept edge.
  task automatic send_word(input req_word_t w);
    @(negedge clk);
    while ($urandom_range(1, 100) <= src_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= w.func;
    req_ch.idx_a <= w.a;
    req_ch.idx_b <= w.b;
    req_ch.idx_c <= w.c;
    req_ch.idx_d <= w.d;
    req_ch.idx_e <= w.e;
    req_ch.idx_f <= w.f;
    req_ch.entry_value <= w.value;
    do @(posedge clk); while (!req_ch.ready);
    ledger.note_word(w);
    n_sent++;
  endtask

  task automatic load_entry(input logic [1:0] func, input idx_t a, b, c, d, e, f,
                            input logic [63:0] value);
    req_word_t w;
    w = {func, a, b, c, d, e, f, value};
    // Index fields past the tensor order are don't-care; scramble them.
    if (func == FUNC_ONE) begin
      w.c = idx_t'($urandom);
      w.d = idx_t'($urandom);
    end
    if (func != FUNC_THREE) begin
      w.e = idx_t'($urandom);
      w.f = idx_t'($urandom);
    end
    case (func)
      FUNC_ONE:   one_done[{a, b}] = 1'b1;
      FUNC_TWO:   two_done[{a, b, c, d}] = 1'b1;
      default:    three_done[{a, b, c, d, e, f}] = 1'b1;
    endcase
    send_word(w);
  endtask

  // Loads whatever the query would read that is still unwritten, then queries.
  task automatic query_element(input idx_t i, j, k, l, m, n);
    req_word_t w;
    if (!one_done[{i, n}]) load_entry(FUNC_ONE, i, n, 0, 0, 0, 0, entry_bits());
    if (!two_done[{i, m, n, l}]) load_entry(FUNC_TWO, i, m, n, l, 0, 0, entry_bits());
    if (!two_done[{i, k, n, j}]) load_entry(FUNC_TWO, i, k, n, j, 0, 0, entry_bits());
    if (!two_done[{i, k, l, n}]) load_entry(FUNC_TWO, i, k, l, n, 0, 0, entry_bits());
    if (!three_done[{i, k, m, n, l, j}]) begin
      load_entry(FUNC_THREE, i, k, m, n, l, j, entry_bits());
    end
    w = {FUNC_QUERY, i, j, k, l, m, n, {$urandom, $urandom}};
    send_word(w);
  endtask

  initial begin
    int sel;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme indices, no delta, each delta alone, all deltas, special values.
    load_entry(FUNC_ONE, 0, 0, 0, 0, 0, 0, 64'h3FF0_0000_0000_0000);
    load_entry(FUNC_TWO, 0, 0, 0, 0, 0, 0, 64'hBFE0_0000_0000_0000);
    load_entry(FUNC_THREE, 0, 0, 0, 0, 0, 0, 64'h0000_0000_0000_0000);
    query_element(0, 0, 0, 0, 0, 0);
    load_entry(FUNC_ONE, 3, 3, 0, 0, 0, 0, 64'h7FF0_0000_0000_0000);
    query_element(3, 3, 3, 3, 3, 3);
    load_entry(FUNC_THREE, 3, 3, 3, 3, 3, 3, 64'hFFF0_0000_0000_0000);
    query_element(3, 3, 3, 3, 3, 3);
    load_entry(FUNC_THREE, 1, 2, 3, 0, 0, 1, 64'h3CF0_0000_0000_0000);
    query_element(1, 1, 2, 0, 3, 0);
    load_entry(FUNC_THREE, 1, 2, 3, 0, 0, 1, 64'h3D10_0000_0000_0000);
    query_element(1, 1, 2, 0, 3, 0);
    load_entry(FUNC_THREE, 1, 2, 3, 0, 0, 1, 64'hBD10_0000_0000_0000);
    query_element(1, 1, 2, 0, 3, 0);
    load_entry(FUNC_THREE, 2, 0, 1, 3, 3, 2, 64'h7FF8_0000_0000_0001);
    query_element(2, 2, 0, 3, 1, 3);
    query_element(0, 1, 1, 2, 3, 2);
    query_element(0, 1, 2, 3, 3, 1);
    query_element(2, 1, 0, 2, 1, 3);

    // Random: four flow-control phases, paced by the words sent so far.
    while (n_sent < 1450) begin
      case (n_sent / 363)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 56; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 56; end
        default: begin src_idle = 18; snk_stall = 18; end
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        query_element(idx_t'($urandom), idx_t'($urandom), idx_t'($urandom),
                      idx_t'($urandom), idx_t'($urandom), idx_t'($urandom));
      end else begin
        load_entry(2'($urandom_range(0, 2)), idx_t'($urandom), idx_t'($urandom),
                   idx_t'($urandom), idx_t'($urandom), idx_t'($urandom),
                   idx_t'($urandom), entry_bits());
      end
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Drain, then allow for the pipeline depth.
    while (ledger.owed_elements.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
